@@ sv/spx_pkg.sv @@
// Shared types, constants and mode table for the scanline pixel expander.
package spx_pkg;

   localparam int SPX_QUEUE_DEPTH = 4;

   localparam int ROW_W   = 10;
   localparam int COL_W   = 9;
   localparam int BYTE_W  = 8;
   localparam int ADDR_W  = 19;
   localparam int DIM_W   = 10;
   localparam int MODE_W  = 4;
   localparam int PAL_W   = 64;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_LSB = 3;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   // register indexes on the configuration port
   localparam logic [1:0] REG_MODE     = 2'd0;
   localparam logic [1:0] REG_PAL_LOW  = 2'd1;
   localparam logic [1:0] REG_PAL_HIGH = 2'd2;

   localparam logic [MODE_W-1:0] MODE_MAX = 4'd10;

   // depth codes: log2 of bits per pixel
   localparam logic [1:0] BPP1 = 2'd0;
   localparam logic [1:0] BPP2 = 2'd1;
   localparam logic [1:0] BPP4 = 2'd2;
   localparam logic [1:0] BPP8 = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [PAL_W-1:0]  pal_low;
      logic [PAL_W-1:0]  pal_high;
   } spx_cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [ADDR_W-1:0] addr;
      logic [1:0]        code;
   } spx_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } spx_qstat_type;

   function automatic logic [MODE_W-1:0] mode_select(input logic [MODE_W-1:0] m);
      mode_select = (m > MODE_MAX) ? '0 : m;
   endfunction

   function automatic logic [DIM_W-1:0] mode_width(input logic [MODE_W-1:0] m);
      case (m)
         4'd4:    mode_width = 10'd352;
         4'd5:    mode_width = 10'd496;
         4'd6:    mode_width = 10'd704;
         4'd7:    mode_width = 10'd304;
         4'd8:    mode_width = 10'd448;
         4'd9:    mode_width = 10'd624;
         4'd10:   mode_width = 10'd896;
         default: mode_width = 10'd256;
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] mode_height(input logic [MODE_W-1:0] m);
      case (m)
         4'd4:    mode_height = 10'd352;
         4'd5:    mode_height = 10'd496;
         4'd6:    mode_height = 10'd704;
         4'd7:    mode_height = 10'd208;
         4'd8:    mode_height = 10'd288;
         4'd9:    mode_height = 10'd416;
         4'd10:   mode_height = 10'd576;
         default: mode_height = 10'd256;
      endcase
   endfunction

   function automatic logic [1:0] mode_code(input logic [MODE_W-1:0] m);
      case (m)
         4'd1, 4'd4, 4'd8:  mode_code = BPP4;
         4'd2, 4'd5, 4'd9:  mode_code = BPP2;
         4'd3, 4'd6, 4'd10: mode_code = BPP1;
         default:           mode_code = BPP8;
      endcase
   endfunction

   // pixels per byte minus one
   function automatic logic [2:0] ppb_last(input logic [1:0] code);
      case (code)
         BPP1:    ppb_last = 3'd7;
         BPP2:    ppb_last = 3'd3;
         BPP4:    ppb_last = 3'd1;
         default: ppb_last = 3'd0;
      endcase
   endfunction

endpackage

@@ sv/scanline_pixel_expander.sv @@
// Scanline pixel expander top level: register file, front end, queue and back end.
//
// Each accepted word carries one packed video byte with its row and byte column; the
// block emits one pixel word per cycle while rsp_tready does not stall it, so a byte
// yields 1, 2, 4 or 8 pixels at 8, 4, 2 or 1 bpp, set by the back end that walks
// the fields of one byte at a time. The front end takes a new byte every cycle while
// the QUEUE_DEPTH-entry queue has room; a byte whose row or column lies outside the
// current mode is dropped there and produces no pixel. Pixels come out in input order,
// the last one of each byte flagged by rsp_tlast. Mode and palette must be written
// only while the block is idle; the block itself does not enforce this.
module scanline_pixel_expander
   import spx_pkg::*;
#(
   parameter int QUEUE_DEPTH = SPX_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [9:0] row, [18:10] byte_column, [26:19] packed_byte
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] pixel_color, [26:8] pixel_address
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   spx_cfg_type   cfg;
   spx_qstat_type qstat;
   spx_cmd_type   push_cmd;
   spx_cmd_type   head;
   logic          push;
   logic          pop;

   spx_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   spx_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .qstat      (qstat),
      .push       (push),
      .cmd        (push_cmd)
   );

   spx_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   spx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_queue_consistent: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("queue reports full and empty at once");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("command pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("command popped from an empty queue");

endmodule

@@ sv/spx_csr.sv @@
// Configuration register file: mode and the two palette words.
module spx_csr
   import spx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output spx_cfg_type           cfg
);

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [PAL_W-1:0]  pal_low_ff, pal_low_in;
   logic [PAL_W-1:0]  pal_high_ff, pal_high_in;
   logic [1:0]        idx;
   logic              wr;

   assign idx = csr_paddr[CSR_IDX_LSB +: 2];
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      mode_in     = mode_ff;
      pal_low_in  = pal_low_ff;
      pal_high_in = pal_high_ff;
      if (wr) begin
         case (idx)
            REG_MODE:     mode_in     = csr_pwdata[MODE_W-1:0];
            REG_PAL_LOW:  pal_low_in  = csr_pwdata;
            REG_PAL_HIGH: pal_high_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= '0;
         pal_low_ff  <= '0;
         pal_high_ff <= '0;
      end else begin
         mode_ff     <= mode_in;
         pal_low_ff  <= pal_low_in;
         pal_high_ff <= pal_high_in;
      end
   end

   always_comb begin
      case (idx)
         REG_MODE:     csr_prdata = {{(CSR_DATA_W-MODE_W){1'b0}}, mode_ff};
         REG_PAL_LOW:  csr_prdata = pal_low_ff;
         REG_PAL_HIGH: csr_prdata = pal_high_ff;
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg = '{mode: mode_ff, pal_low: pal_low_ff, pal_high: pal_high_ff};

endmodule

@@ sv/spx_front.sv @@
// Front end: accepts packed bytes, range-checks them and computes the base address.
module spx_front
   import spx_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  spx_cfg_type           cfg,
   input  spx_qstat_type         qstat,
   output logic                  push,
   output spx_cmd_type           cmd
);

   logic [ROW_W-1:0]  row;
   logic [COL_W-1:0]  col;
   logic [BYTE_W-1:0] data;
   logic [MODE_W-1:0] m;
   logic [DIM_W-1:0]  width;
   logic [DIM_W-1:0]  height;
   logic [1:0]        code;
   logic [DIM_W-1:0]  row_bytes;
   logic [COL_W+2:0]  col_pix;
   logic [ROW_W+DIM_W-1:0] base;
   logic              in_range;

   assign row  = req_tdata[ROW_W-1:0];
   assign col  = req_tdata[ROW_W +: COL_W];
   assign data = req_tdata[ROW_W+COL_W +: BYTE_W];

   assign m      = mode_select(cfg.mode);
   assign width  = mode_width(m);
   assign height = mode_height(m);
   assign code   = mode_code(m);

   always_comb begin
      case (code)
         BPP1: begin
            row_bytes = width >> 3;
            col_pix   = {col, 3'b000};
         end
         BPP2: begin
            row_bytes = width >> 2;
            col_pix   = {1'b0, col, 2'b00};
         end
         BPP4: begin
            row_bytes = width >> 1;
            col_pix   = {2'b00, col, 1'b0};
         end
         default: begin
            row_bytes = width;
            col_pix   = {3'b000, col};
         end
      endcase
   end

   assign base = row * width + (ROW_W+DIM_W)'(col_pix);
   assign in_range = (row < height) && ({1'b0, col} < row_bytes);

   // drop out-of-range bytes at the door; they are still accepted on the input handshake
   assign req_tready = !qstat.full;
   assign push       = req_tvalid && req_tready && in_range;
   assign cmd        = '{data: data, addr: base[ADDR_W-1:0], code: code};

endmodule

@@ sv/spx_fifo.sv @@
// Short command queue between the front and back ends.
module spx_fifo
   import spx_pkg::*;
#(
   parameter int DEPTH = SPX_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  spx_cmd_type   push_cmd,
   input  logic          pop,
   output spx_cmd_type   head,
   output spx_qstat_type qstat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   spx_cmd_type      mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head        = mem[rd_ptr_ff];
   assign qstat.full  = (count_ff == CNT_W'(DEPTH));
   assign qstat.empty = (count_ff == '0);

endmodule

@@ sv/spx_back.sv @@
// Back end: walks the fields of one byte and emits one pixel word per cycle unless rsp_tready stalls it.
module spx_back
   import spx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  spx_cfg_type           cfg,
   input  spx_cmd_type           head,
   input  spx_qstat_type         qstat,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic              busy_ff, busy_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [1:0]        code_ff, code_in;
   logic [2:0]        cnt_ff, cnt_in;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] color_ff, color_in;
   logic [ADDR_W-1:0] oaddr_ff, oaddr_in;
   logic              last_ff, last_in;

   logic                  out_adv;
   logic                  emit;
   logic                  last;
   logic [3:0]            field;
   logic [2*PAL_W-1:0]    pal;
   logic [BYTE_W-1:0]     color;
   logic [BYTE_W-1:0]     data_shl;

   assign out_adv = !valid_ff || rsp_tready;
   assign emit    = busy_ff && out_adv;
   assign last    = (cnt_ff == '0);
   assign pop     = !qstat.empty && (!busy_ff || (emit && last));
   assign pal     = {cfg.pal_high, cfg.pal_low};

   // top field of the shifting byte is the next pixel; at 8 bpp the whole byte is the color
   always_comb begin
      case (code_ff)
         BPP1: begin
            field    = {3'b000, data_ff[7]};
            data_shl = {data_ff[6:0], 1'b0};
         end
         BPP2: begin
            field    = {2'b00, data_ff[7:6]};
            data_shl = {data_ff[5:0], 2'b00};
         end
         BPP4: begin
            field    = data_ff[7:4];
            data_shl = {data_ff[3:0], 4'b0000};
         end
         default: begin
            field    = data_ff[7:4];
            data_shl = data_ff;
         end
      endcase
      color = (code_ff == BPP8) ? data_ff : pal[{field, 3'b000} +: BYTE_W];
   end

   always_comb begin
      busy_in = busy_ff;
      data_in = data_ff;
      addr_in = addr_ff;
      code_in = code_ff;
      cnt_in  = cnt_ff;
      if (pop) begin
         busy_in = 1'b1;
         data_in = head.data;
         addr_in = head.addr;
         code_in = head.code;
         cnt_in  = ppb_last(head.code);
      end else if (emit && last) begin
         busy_in = 1'b0;
      end else if (emit) begin
         data_in = data_shl;
         addr_in = addr_ff + ADDR_W'(1);
         cnt_in  = cnt_ff - 3'd1;
      end

      valid_in = valid_ff;
      color_in = color_ff;
      oaddr_in = oaddr_ff;
      last_in  = last_ff;
      if (out_adv) begin
         valid_in = emit;
         color_in = color;
         oaddr_in = addr_ff;
         last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      addr_ff  <= addr_in;
      code_ff  <= code_in;
      cnt_ff   <= cnt_in;
      color_ff <= color_in;
      oaddr_ff <= oaddr_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-BYTE_W-ADDR_W){1'b0}}, oaddr_ff, color_ff};
   assign rsp_tlast  = last_ff;

endmodule
